// ===== rtl/ecd_pkg.sv =====
// Shared types, codes and the CRC-32 byte step for the encrypted chunk deframer.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindIv      = 2'd1,
    KindReport  = 2'd2
  } item_kind_e;

  // Status carried by a chunk-end report.
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadMagic   = 3'd1,
    StBadOrig    = 3'd2,
    StBadEnc     = 3'd3,
    StBadIv      = 3'd4,
    StCrcError   = 3'd5,
    StIncomplete = 3'd6
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgMagicOne   = 2'd0;
  localparam logic [1:0] CfgMagicTwo   = 2'd1;
  localparam logic [1:0] CfgMagicThree = 2'd2;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // Depth of the result queue and its pointer width.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One result item.
  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data;
    status_e     status;
    logic [1:0]  version;
    logic [30:0] orig_size;
    logic [30:0] enc_size;
    logic        hash;
    logic        last;
  } result_t;

  // Results produced by one input item, in order: first, then second.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ecd_parser.sv =====
// Chunk parser: header field capture, IV and payload pass-through, CRC check and reports.
`timescale 1ns / 1ps
`default_nettype none

module ecd_parser #(
  parameter int unsigned MAGIC_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i,
  input  wire logic              item_valid_i,
  input  wire logic [7:0]        item_byte_i,
  input  wire logic              item_eos_i,
  output      ecd_pkg::push_t    push_o
);
  import ecd_pkg::*;

  // Parse phase codes.
  localparam logic [2:0] PhMagic = 3'd0;
  localparam logic [2:0] PhRsvd  = 3'd1;
  localparam logic [2:0] PhOrig  = 3'd2;
  localparam logic [2:0] PhEnc   = 3'd3;
  localparam logic [2:0] PhCrc   = 3'd4;
  localparam logic [2:0] PhIvLen = 3'd5;
  localparam logic [2:0] PhIv    = 3'd6;
  localparam logic [2:0] PhPay   = 3'd7;

  localparam logic [63:0] MagicMask = {64{1'b1}} >> (64 - 8 * MAGIC_BYTES);
  localparam logic [3:0]  MagicLen  = 4'(MAGIC_BYTES);

  logic [63:0] magic1_q, magic2_q, magic3_q;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [63:0] shift_q, shift_d;
  logic [1:0]  ver_q, ver_d;
  logic [30:0] orig_q, orig_d;
  logic [30:0] enc_q, enc_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] crc_q, crc_d;
  logic [30:0] left_q, left_d;
  logic        err_q, err_d;

  result_t     res [2];
  logic [1:0]  cnt;
  logic        clr;
  logic        fin;
  logic [31:0] fin_crc;
  logic        enter_pay;
  logic [63:0] shift_n;
  logic [3:0]  fbc_n;
  logic [3:0]  flen;
  logic [30:0] left_n;
  logic [31:0] crc_n;
  logic [63:0] fv;

  // Build a chunk-end report from the captured header state.
  function automatic result_t report(status_e st, logic hash, logic last,
                                     logic [1:0] ver, logic [30:0] osz,
                                     logic [30:0] esz);
    result_t r;
    r.kind      = KindReport;
    r.data      = 8'd0;
    r.status    = st;
    r.version   = ver;
    r.orig_size = osz;
    r.enc_size  = esz;
    r.hash      = hash;
    r.last      = last;
    return r;
  endfunction

  // Build a byte result of the given kind.
  function automatic result_t byte_item(item_kind_e k, logic [7:0] b);
    result_t r;
    r           = '0;
    r.kind      = k;
    r.data      = b;
    r.status    = StOk;
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic1_q <= '0;
      magic2_q <= '0;
      magic3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMagicOne:   magic1_q <= cfg_data_i;
        CfgMagicTwo:   magic2_q <= cfg_data_i;
        CfgMagicThree: magic3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One parse step for the registered request.
  always_comb begin
    phase_d   = phase_q;
    fbc_d     = fbc_q;
    shift_d   = shift_q;
    ver_d     = ver_q;
    orig_d    = orig_q;
    enc_d     = enc_q;
    exp_d     = exp_q;
    crc_d     = crc_q;
    left_d    = left_q;
    err_d     = err_q;
    res[0]    = '0;
    res[1]    = '0;
    cnt       = 2'd0;
    clr       = 1'b0;
    fin       = 1'b0;
    fin_crc   = crc_q;
    enter_pay = 1'b0;
    left_n    = left_q - 31'd1;
    crc_n     = crc_byte(crc_q, item_byte_i);
    shift_n   = shift_q | (64'(item_byte_i) << {fbc_q[2:0], 3'b000});
    fbc_n     = fbc_q + 4'd1;
    fv        = shift_n & MagicMask;
    case (phase_q)
      PhMagic: flen = MagicLen;
      PhCrc:   flen = 4'd4;
      default: flen = 4'd8;
    endcase

    if (item_valid_i) begin
      if (item_eos_i) begin
        // End of buffer: release an error hold, or close an open chunk.
        if (err_q) begin
          err_d = 1'b0;
          clr   = 1'b1;
        end else if (!(phase_q == PhMagic && fbc_q == 4'd0)) begin
          res[0] = report(StIncomplete, 1'b0, 1'b1, ver_q, orig_q, enc_q);
          cnt    = 2'd1;
          clr    = 1'b1;
        end
      end else if (!err_q) begin
        if (phase_q == PhIv) begin
          // IV bytes pass only for version three.
          if (ver_q == 2'd3) begin
            res[0] = byte_item(KindIv, item_byte_i);
            cnt    = 2'd1;
          end
          left_d = left_n;
          if (left_n == 31'd0) begin
            enter_pay = 1'b1;
          end
        end else if (phase_q == PhPay) begin
          // Payload byte goes out and into the running CRC.
          res[0]  = byte_item(KindPayload, item_byte_i);
          cnt     = 2'd1;
          crc_d   = crc_n;
          left_d  = left_n;
          if (left_n == 31'd0) begin
            fin     = 1'b1;
            fin_crc = crc_n;
          end
        end else begin
          // Header field capture, little-endian.
          shift_d = shift_n;
          fbc_d   = fbc_n;
          if (fbc_n >= flen) begin
            fbc_d   = 4'd0;
            shift_d = '0;
            case (phase_q)
              PhMagic: begin
                phase_d = PhRsvd;
                if (fv == (magic3_q & MagicMask)) begin
                  ver_d = 2'd3;
                end else if (fv == (magic2_q & MagicMask)) begin
                  ver_d = 2'd2;
                end else if (fv == (magic1_q & MagicMask)) begin
                  ver_d = 2'd1;
                end else begin
                  res[0] = report(StBadMagic, 1'b0, 1'b1, ver_q, orig_q, enc_q);
                  cnt    = 2'd1;
                  clr    = 1'b1;
                  err_d  = 1'b1;
                end
              end
              PhRsvd: phase_d = PhOrig;
              PhOrig: begin
                phase_d = PhEnc;
                orig_d  = shift_n[30:0];
                if (|shift_n[63:31]) begin
                  res[0] = report(StBadOrig, 1'b0, 1'b1, ver_q, orig_q, enc_q);
                  cnt    = 2'd1;
                  clr    = 1'b1;
                  err_d  = 1'b1;
                end
              end
              PhEnc: begin
                phase_d = PhCrc;
                enc_d   = shift_n[30:0];
                if (|shift_n[63:31]) begin
                  res[0] = report(StBadEnc, 1'b0, 1'b1, ver_q, orig_q, enc_q);
                  cnt    = 2'd1;
                  clr    = 1'b1;
                  err_d  = 1'b1;
                end
              end
              PhCrc: begin
                exp_d   = shift_n[31:0];
                phase_d = PhIvLen;
                if (ver_q == 2'd1) begin
                  enter_pay = 1'b1;
                end
              end
              default: begin
                // IV length word.
                phase_d = PhIv;
                left_d  = shift_n[30:0];
                if (|shift_n[63:31]) begin
                  res[0] = report(StBadIv, 1'b0, 1'b1, ver_q, orig_q, enc_q);
                  cnt    = 2'd1;
                  clr    = 1'b1;
                  err_d  = 1'b1;
                end else if (shift_n[30:0] == 31'd0) begin
                  enter_pay = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end

    // Move to the payload; an empty payload finishes the chunk at once.
    if (enter_pay) begin
      phase_d = PhPay;
      fbc_d   = 4'd0;
      shift_d = '0;
      left_d  = enc_q;
      if (enc_q == 31'd0) begin
        fin = 1'b1;
      end
    end

    // Chunk complete: check the CRC and report.
    if (fin) begin
      clr = 1'b1;
      if (~fin_crc != exp_d) begin
        res[cnt[0]] = report(StCrcError, 1'b0, 1'b1, ver_q, orig_q, enc_q);
        err_d       = 1'b1;
      end else begin
        res[cnt[0]] = report(StOk, ver_q == 2'd3, 1'b0, ver_q, orig_q, enc_q);
      end
      cnt = cnt + 2'd1;
    end

    // Back to a chunk boundary.
    if (clr) begin
      phase_d = PhMagic;
      fbc_d   = 4'd0;
      shift_d = '0;
      ver_d   = 2'd0;
      orig_d  = '0;
      enc_d   = '0;
      exp_d   = '0;
      crc_d   = '1;
      left_d  = '0;
    end
  end

  assign push_o.count  = cnt;
  assign push_o.first  = res[0];
  assign push_o.second = res[1];

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic;
      fbc_q   <= '0;
      shift_q <= '0;
      ver_q   <= '0;
      orig_q  <= '0;
      enc_q   <= '0;
      exp_q   <= '0;
      crc_q   <= '1;
      left_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      shift_q <= shift_d;
      ver_q   <= ver_d;
      orig_q  <= orig_d;
      enc_q   <= enc_d;
      exp_q   <= exp_d;
      crc_q   <= crc_d;
      left_q  <= left_d;
      err_q   <= err_d;
    end
  end

`ifndef ASSERT_OFF
  // A byte phase always has bytes left to take.
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIv || phase_q == PhPay) |-> left_q != 31'd0)
    else $error("IV or payload phase with no bytes left");

  // While an error is held the parser sits at a chunk boundary.
  a_hold_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (phase_q == PhMagic && fbc_q == 4'd0))
    else $error("error hold outside a chunk boundary");

  // Nothing comes out of bytes that arrive during an error hold.
  a_hold_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && err_q && !item_eos_i) |-> push_o.count == 2'd0)
    else $error("result produced during error hold");

  // A second result is always the chunk-end report.
  a_second_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> push_o.second.kind == KindReport)
    else $error("second result is not a report");
`endif

endmodule

`default_nettype wire

// ===== rtl/ecd_result_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready_i is high.
`timescale 1ns / 1ps
`default_nettype none

module ecd_result_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ecd_pkg::push_t    push_i,
  output      logic              room_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      ecd_pkg::result_t  out_o
);
  import ecd_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;
  logic [QPtrW-1:0]  wptr_1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rptr_q];
  assign room_o      = cnt_q <= QCntW'(QDepth - 2);
  assign wptr_1      = wptr_q + QPtrW'(1);
  assign cnt_d       = cnt_q + QCntW'(push_i.count) - QCntW'(pop);

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_1] <= push_i.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QPtrW'(push_i.count);
      rptr_q <= rptr_q + QPtrW'(pop);
      cnt_q  <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // Results only arrive when two slots were free.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("result queue written without room");

  // The fill count follows pushes and pops.
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_d))
    else $error("result queue count out of step");
`endif

endmodule

`default_nettype wire

// ===== rtl/encrypted_chunk_deframer_top.sv =====
// Top level of the encrypted chunk deframer: input register, parser and result queue.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] stream byte; tlast end of stream
//  m_axis    out        tuser item kind; tdata sizes/status/byte; tlast run closed
//  cfg       in         write enable, register index, 64-bit magic value
//
// Each input request is registered, then parsed one byte per cycle while the result queue has room.
// A result passes through the input register and the result queue before it shows on m_axis.
// The last payload byte of a chunk, or the last IV byte of a version three chunk with
// an empty payload, yields two results; the output side moves one per cycle while m_axis_tready is high.
// The input stalls when the four-entry result queue has fewer than two free slots.
// Reset clears the parser, the queue and the magic registers; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module encrypted_chunk_deframer_top #(
  parameter int unsigned MAGIC_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  wire logic        s_axis_tlast,   // end_of_stream
  // Output stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [79:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status,
                                           // [12:11] chunk_version, [43:13] original_size,
                                           // [74:44] encrypted_size, [75] hash_flag,
                                           // [79:76] zero
  output      logic [1:0]  m_axis_tuser,   // item_kind
  output      logic        m_axis_tlast    // chunk_last
);
  import ecd_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  logic       room;
  logic       proc;
  push_t      push;
  result_t    head;

  assign proc          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || proc;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  ecd_parser #(
    .MAGIC_BYTES (MAGIC_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (proc),
    .item_byte_i  (in_byte_q),
    .item_eos_i   (in_eos_q),
    .push_o       (push)
  );

  ecd_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (head)
  );

  // Output packing.
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {4'd0, head.hash, head.enc_size, head.orig_size,
                         head.version, head.status, head.data};

endmodule

`default_nettype wire
